// ----- rtl/avcc_pkg.sv -----
// Shared types, codes and constants of the AVCC to Annex B converter.
package avcc_pkg;

  // Front parser phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PREFIX,
    PH_NAL_FIRST,
    PH_NAL_BODY,
    PH_DRAIN
  } phase_t;

  // Header that precedes the data of one command
  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_AUD,   // start code plus access unit delimiter, six bytes
    HDR_SC     // start code only, four bytes
  } hdr_t;

  // Input kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // Sample status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TRUNC   = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  // NAL unit types
  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;
  localparam logic [4:0] NAL_AUD = 5'd9;

  // Header bytes
  localparam logic [7:0] SC_ZERO     = 8'h00;
  localparam logic [7:0] SC_LAST     = 8'h01;
  localparam logic [7:0] AUD_HEADER  = 8'h09;
  localparam logic [7:0] AUD_PAYLOAD = 8'hF0;

  localparam logic [2:0] AUD_HDR_LAST = 3'd5;
  localparam logic [2:0] SC_HDR_LAST  = 3'd3;

  // Prefix size limits
  localparam logic [2:0] PFX_MIN   = 3'd1;
  localparam logic [2:0] PFX_MAX   = 3'd4;
  localparam logic [2:0] PFX_RESET = 3'd4;

  // Command queue between parser and output sequencer
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // One command: optional header, optional data byte, optional status
  typedef struct packed {
    hdr_t       hdr;
    logic       byte_en;
    logic [7:0] data;
    logic       stat_en;
    logic [1:0] stat;
  } cmd_t;

  // Byte of a header at a given position
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd3:    b = SC_LAST;
      3'd4:    b = AUD_HEADER;
      3'd5:    b = AUD_PAYLOAD;
      default: b = SC_ZERO;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/avcc_cmdq.sv -----
// Short command queue between the parser front and the output back.
module avcc_cmdq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  avcc_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output avcc_pkg::cmd_t  head_cmd
);

  avcc_pkg::cmd_t mem_r [avcc_pkg::CMDQ_DEPTH];

  logic [avcc_pkg::CMDQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [avcc_pkg::CMDQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [avcc_pkg::CMDQ_AW:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full       = (cnt_r == (avcc_pkg::CMDQ_AW + 1)'(avcc_pkg::CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/avcc_front.sv -----
// Parser front: takes items, tracks prefix and NAL state, issues commands.
module avcc_front #(
  parameter int SAMPLE_LENGTH_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [2:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [7:0]                    in_data_byte,
  input  logic [SAMPLE_LENGTH_BITS-1:0] in_sample_length,
  input  logic                          in_drop_param_sets,
  input  logic                          q_full,
  output logic                          q_push,
  output avcc_pkg::cmd_t                q_cmd
);

  localparam int LW = SAMPLE_LENGTH_BITS;

  avcc_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]    lpb_r;
  logic [LW-1:0] sl_r, sl_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [2:0]    seen_r, seen_nxt;
  logic [LW-1:0] nal_r, nal_nxt;
  logic          dropping_r, dropping_nxt;
  logic          flag_r, flag_nxt;

  logic          fire;
  logic [2:0]    psize;
  logic [LW-1:0] sl_dec;
  logic [31:0]   acc_new;
  logic [2:0]    seen_inc;
  logic          pfx_done;
  logic [LW-1:0] nal_dec;
  logic [4:0]    unit_type;
  logic          drop_now;
  logic [LW-1:0] bnd_sl;
  logic          bnd_zero;
  logic          bnd_trunc;
  logic          ev_bnd, ev_ovr, ev_nal;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // Effective prefix size, clamped to 1..4
  always_comb begin
    if (lpb_r < avcc_pkg::PFX_MIN) begin
      psize = avcc_pkg::PFX_MIN;
    end else if (lpb_r > avcc_pkg::PFX_MAX) begin
      psize = avcc_pkg::PFX_MAX;
    end else begin
      psize = lpb_r;
    end
  end

  // Per-byte arithmetic
  assign sl_dec    = sl_r - 1'b1;
  assign acc_new   = {acc_r[23:0], in_data_byte};
  assign seen_inc  = seen_r + 1'b1;
  assign pfx_done  = (seen_inc >= psize);
  assign nal_dec   = nal_r - 1'b1;
  assign unit_type = in_data_byte[4:0];
  assign drop_now  = (unit_type == avcc_pkg::NAL_AUD) ||
                     (flag_r && ((unit_type == avcc_pkg::NAL_SPS) ||
                                 (unit_type == avcc_pkg::NAL_PPS)));

  // Bytes left as seen at a NAL boundary
  assign bnd_sl    = (in_kind == avcc_pkg::KIND_START) ? in_sample_length : sl_dec;
  assign bnd_zero  = (bnd_sl == '0);
  assign bnd_trunc = (bnd_sl < LW'(psize));

  // Classify the item
  always_comb begin
    ev_bnd = 1'b0;
    ev_ovr = 1'b0;
    ev_nal = 1'b0;
    if (in_kind == avcc_pkg::KIND_START) begin
      ev_bnd = 1'b1;
    end else begin
      case (phase_r)
        avcc_pkg::PH_PREFIX: begin
          if (pfx_done) begin
            if (acc_new == '0) begin
              ev_bnd = 1'b1;
            end else if ({1'b0, acc_new} > 33'(sl_dec)) begin
              ev_ovr = 1'b1;
            end else begin
              ev_nal = 1'b1;
            end
          end
        end
        avcc_pkg::PH_NAL_FIRST, avcc_pkg::PH_NAL_BODY: begin
          if (nal_dec == '0) begin
            ev_bnd = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    sl_nxt       = sl_r;
    acc_nxt      = acc_r;
    seen_nxt     = seen_r;
    nal_nxt      = nal_r;
    dropping_nxt = dropping_r;
    flag_nxt     = flag_r;
    if (fire) begin
      if (in_kind == avcc_pkg::KIND_START) begin
        sl_nxt       = in_sample_length;
        flag_nxt     = in_drop_param_sets;
        dropping_nxt = 1'b0;
        nal_nxt      = '0;
      end else begin
        case (phase_r)
          avcc_pkg::PH_PREFIX: begin
            acc_nxt  = acc_new;
            seen_nxt = seen_inc;
            sl_nxt   = sl_dec;
            if (ev_ovr) begin
              phase_nxt = (sl_dec == '0) ? avcc_pkg::PH_IDLE : avcc_pkg::PH_DRAIN;
            end
            if (ev_nal) begin
              nal_nxt   = acc_new[LW-1:0];
              phase_nxt = avcc_pkg::PH_NAL_FIRST;
            end
          end
          avcc_pkg::PH_NAL_FIRST: begin
            dropping_nxt = drop_now;
            phase_nxt    = avcc_pkg::PH_NAL_BODY;
            sl_nxt       = sl_dec;
            nal_nxt      = nal_dec;
          end
          avcc_pkg::PH_NAL_BODY: begin
            sl_nxt  = sl_dec;
            nal_nxt = nal_dec;
          end
          avcc_pkg::PH_DRAIN: begin
            sl_nxt = sl_dec;
            if (sl_dec == '0) begin
              phase_nxt = avcc_pkg::PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      // NAL boundary: close the sample or open a new prefix
      if (ev_bnd) begin
        if (bnd_zero) begin
          phase_nxt = avcc_pkg::PH_IDLE;
        end else if (bnd_trunc) begin
          phase_nxt = avcc_pkg::PH_DRAIN;
        end else begin
          phase_nxt = avcc_pkg::PH_PREFIX;
          acc_nxt   = '0;
          seen_nxt  = '0;
        end
      end
    end
  end

  // Command for the back
  always_comb begin
    q_cmd = '0;
    q_cmd.hdr = avcc_pkg::HDR_NONE;
    if (in_kind == avcc_pkg::KIND_START) begin
      q_cmd.hdr = avcc_pkg::HDR_AUD;
    end else begin
      case (phase_r)
        avcc_pkg::PH_NAL_FIRST: begin
          if (!drop_now) begin
            q_cmd.hdr     = avcc_pkg::HDR_SC;
            q_cmd.byte_en = 1'b1;
            q_cmd.data    = in_data_byte;
          end
        end
        avcc_pkg::PH_NAL_BODY: begin
          if (!dropping_r) begin
            q_cmd.byte_en = 1'b1;
            q_cmd.data    = in_data_byte;
          end
        end
        default: ;
      endcase
    end
    if (ev_bnd && (bnd_zero || bnd_trunc)) begin
      q_cmd.stat_en = 1'b1;
      q_cmd.stat    = bnd_zero ? avcc_pkg::ST_OK : avcc_pkg::ST_TRUNC;
    end
    if (ev_ovr) begin
      q_cmd.stat_en = 1'b1;
      q_cmd.stat    = avcc_pkg::ST_OVERRUN;
    end
    q_push = fire && ((q_cmd.hdr != avcc_pkg::HDR_NONE) || q_cmd.byte_en || q_cmd.stat_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= avcc_pkg::PH_IDLE;
      lpb_r      <= avcc_pkg::PFX_RESET;
      sl_r       <= '0;
      acc_r      <= '0;
      seen_r     <= '0;
      nal_r      <= '0;
      dropping_r <= 1'b0;
      flag_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      sl_r       <= sl_nxt;
      acc_r      <= acc_nxt;
      seen_r     <= seen_nxt;
      nal_r      <= nal_nxt;
      dropping_r <= dropping_nxt;
      flag_r     <= flag_nxt;
      if (cfg_valid) begin
        lpb_r <= cfg_data;
      end
    end
  end

endmodule

// ----- rtl/avcc_back.sv -----
// Output back: expands queued commands into stream bytes and status items.
module avcc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  avcc_pkg::cmd_t  q_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_end,
  output logic [1:0]      out_status
);

  avcc_pkg::cmd_t cur_r, cur_nxt;
  logic       hdr_left_r, hdr_left_nxt;
  logic       byte_left_r, byte_left_nxt;
  logic       stat_left_r, stat_left_nxt;
  logic [2:0] hidx_r, hidx_nxt;

  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       obv_r, obv_nxt;
  logic       oend_r, oend_nxt;
  logic [1:0] ost_r, ost_nxt;

  logic       advance;
  logic       cur_valid;
  logic [2:0] hdr_last;

  assign advance   = !ov_r || out_ready;
  assign cur_valid = hdr_left_r || byte_left_r || stat_left_r;
  assign hdr_last  = (cur_r.hdr == avcc_pkg::HDR_AUD) ? avcc_pkg::AUD_HDR_LAST
                                                      : avcc_pkg::SC_HDR_LAST;

  // One piece per cycle unless out_ready stalls; refill from queue when spent
  always_comb begin
    cur_nxt       = cur_r;
    hdr_left_nxt  = hdr_left_r;
    byte_left_nxt = byte_left_r;
    stat_left_nxt = stat_left_r;
    hidx_nxt      = hidx_r;
    ov_nxt        = ov_r;
    ob_nxt        = ob_r;
    obv_nxt       = obv_r;
    oend_nxt      = oend_r;
    ost_nxt       = ost_r;
    q_pop         = 1'b0;

    if (advance) begin
      ov_nxt = 1'b0;
      if (cur_valid) begin
        ov_nxt = 1'b1;
        if (hdr_left_r) begin
          ob_nxt   = avcc_pkg::hdr_byte(hidx_r);
          obv_nxt  = 1'b1;
          oend_nxt = 1'b0;
          ost_nxt  = avcc_pkg::ST_OK;
          if (hidx_r == hdr_last) begin
            hdr_left_nxt = 1'b0;
            hidx_nxt     = '0;
          end else begin
            hidx_nxt = hidx_r + 1'b1;
          end
        end else if (byte_left_r) begin
          ob_nxt        = cur_r.data;
          obv_nxt       = 1'b1;
          oend_nxt      = 1'b0;
          ost_nxt       = avcc_pkg::ST_OK;
          byte_left_nxt = 1'b0;
        end else begin
          ob_nxt        = '0;
          obv_nxt       = 1'b0;
          oend_nxt      = 1'b1;
          ost_nxt       = cur_r.stat;
          stat_left_nxt = 1'b0;
        end
      end
    end

    // Load the next command once the current one has nothing left
    if (!(hdr_left_nxt || byte_left_nxt || stat_left_nxt) && q_valid) begin
      q_pop         = 1'b1;
      cur_nxt       = q_cmd;
      hdr_left_nxt  = (q_cmd.hdr != avcc_pkg::HDR_NONE);
      byte_left_nxt = q_cmd.byte_en;
      stat_left_nxt = q_cmd.stat_en;
      hidx_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_left_r  <= 1'b0;
      byte_left_r <= 1'b0;
      stat_left_r <= 1'b0;
      hidx_r      <= '0;
      ov_r        <= 1'b0;
    end else begin
      hdr_left_r  <= hdr_left_nxt;
      byte_left_r <= byte_left_nxt;
      stat_left_r <= stat_left_nxt;
      hidx_r      <= hidx_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    ob_r   <= ob_nxt;
    obv_r  <= obv_nxt;
    oend_r <= oend_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_byte_valid = obv_r;
  assign out_end        = oend_r;
  assign out_status     = ost_r;

endmodule

// ----- rtl/avcc_to_annexb_converter_core.sv -----
// Top level of the AVCC to Annex B converter: parser, command queue, output back.
//
//  channel | direction | handshake              | content
//  --------+-----------+------------------------+----------------------------------------
//  in_     | slave     | in_tvalid / in_tready  | tuser kind; tdata byte, length, drop
//  out_    | master    | out_tvalid/ out_tready | tdata byte, status; tuser byte flag;
//          |           |                        | tlast end of sample
//  cfg_    | slave     | cfg_valid / cfg_ready  | length prefix size, 3 bits
//
// The parser takes one item per cycle while the 4-entry command queue has room.
// The output register sends one result per cycle while out_tready does not hold it.
// A body byte gives one byte result and a dropped byte none, each plus a status result
// where it closes the sample; a sample start gives up to 7 results, a NAL first byte up to 6.
// Results pass through the command queue, the command register of the back and the output register.
// rst_n is synchronous; it clears the parser state, the queue and the output
// register and sets the prefix size to 4.
// out_tready low holds the output register; the queue fills and in_tready drops.
module avcc_to_annexb_converter_core #(
  parameter int SAMPLE_LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_data,     // length_prefix_bytes
  // input items
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tuser,     // kind
  input  logic [((SAMPLE_LENGTH_BITS + 9 + 7) / 8) * 8 - 1:0] in_tdata,
                                            // data_byte, sample_length, drop_param_sets
  // result items
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,    // out_byte, status
  output logic                out_tuser,    // byte_valid
  output logic                out_tlast     // end_of_sample
);

  localparam int LW = SAMPLE_LENGTH_BITS;

  logic           q_full;
  logic           q_push;
  avcc_pkg::cmd_t q_push_cmd;
  logic           q_pop;
  logic           q_valid;
  avcc_pkg::cmd_t q_head;
  logic [7:0]     ob;
  logic [1:0]     ost;

  assign cfg_ready = 1'b1;

  avcc_front #(
    .SAMPLE_LENGTH_BITS(SAMPLE_LENGTH_BITS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_data           (cfg_data),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .in_kind            (in_tuser),
    .in_data_byte       (in_tdata[7:0]),
    .in_sample_length   (in_tdata[8 +: LW]),
    .in_drop_param_sets (in_tdata[8 + LW]),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (q_push_cmd)
  );

  avcc_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  avcc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_byte       (ob),
    .out_byte_valid (out_tuser),
    .out_end        (out_tlast),
    .out_status     (ost)
  );

  assign out_tdata = {6'd0, ost, ob};

endmodule

// ----- test/annexb_stream_check.sv -----
// Checker for the AVCC to Annex B converter: predicts result items and compares them.
`timescale 1ns / 100ps

module annexb_stream_check #(
  parameter int SLB  = 24,
  parameter int IN_W = 40
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [2:0]      cfg_data,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic            in_tuser,     // kind
  input  logic [IN_W-1:0] in_tdata,     // data_byte, sample_length, drop_param_sets
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [15:0]     out_tdata,    // out_byte, status
  input  logic            out_tuser,    // byte_valid
  input  logic            out_tlast,    // end_of_sample
  output int              fail_count,
  output int              outstanding,
  output int              results_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       is_byte;
    logic       eos;
    logic [1:0] stat;
  } annexb_item_t;

  // Expected items enter at the front and leave at the back
  annexb_item_t annexb_q[$];

  // Mirrored parser state and prefix size register
  avcc_pkg::phase_t parse_phase;
  logic [SLB-1:0]  smp_left;
  logic [31:0]     pfx_acc;
  logic [2:0]      pfx_seen;
  logic [31:0]     nal_left;
  logic            drop_nal;
  logic            drop_ps;
  logic [2:0]      pfx_reg;
  int              fails = 0;
  int              checked = 0;

  function automatic logic [2:0] pfx_size(input logic [2:0] r);
    if (r < avcc_pkg::PFX_MIN) return avcc_pkg::PFX_MIN;
    if (r > avcc_pkg::PFX_MAX) return avcc_pkg::PFX_MAX;
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    annexb_item_t it;
    it = '{data: b, is_byte: 1'b1, eos: 1'b0, stat: avcc_pkg::ST_OK};
    annexb_q.push_front(it);
  endtask

  task automatic push_status(input logic [1:0] st);
    annexb_item_t it;
    it = '{data: 8'h00, is_byte: 1'b0, eos: 1'b1, stat: st};
    annexb_q.push_front(it);
  endtask

  task automatic push_start_code();
    push_byte(avcc_pkg::SC_ZERO);
    push_byte(avcc_pkg::SC_ZERO);
    push_byte(avcc_pkg::SC_ZERO);
    push_byte(avcc_pkg::SC_LAST);
  endtask

  // NAL boundary: close the sample, flag a short prefix, or open a new prefix
  task automatic next_nal();
    if (smp_left == 0) begin
      parse_phase = avcc_pkg::PH_IDLE;
      push_status(avcc_pkg::ST_OK);
    end else if (smp_left < pfx_size(pfx_reg)) begin
      parse_phase = avcc_pkg::PH_DRAIN;
      push_status(avcc_pkg::ST_TRUNC);
    end else begin
      parse_phase = avcc_pkg::PH_PREFIX;
      pfx_acc = '0;
      pfx_seen = '0;
    end
  endtask

  task automatic predict_annexb(input logic kind, input logic [7:0] b,
                                input logic [SLB-1:0] len, input logic drop);
    logic [4:0] unit_type;
    if (kind == avcc_pkg::KIND_START) begin
      smp_left = len;
      drop_ps = drop;
      drop_nal = 1'b0;
      nal_left = '0;
      push_start_code();
      push_byte(avcc_pkg::AUD_HEADER);
      push_byte(avcc_pkg::AUD_PAYLOAD);
      next_nal();
    end else begin
      case (parse_phase)
        avcc_pkg::PH_PREFIX: begin
          pfx_acc = {pfx_acc[23:0], b};
          pfx_seen = pfx_seen + 3'd1;
          smp_left = smp_left - 1'b1;
          if (pfx_seen >= pfx_size(pfx_reg)) begin
            if (pfx_acc == 0) begin
              next_nal();
            end else if (pfx_acc > smp_left) begin
              if (smp_left == 0) parse_phase = avcc_pkg::PH_IDLE;
              else parse_phase = avcc_pkg::PH_DRAIN;
              push_status(avcc_pkg::ST_OVERRUN);
            end else begin
              nal_left = pfx_acc;
              parse_phase = avcc_pkg::PH_NAL_FIRST;
            end
          end
        end
        avcc_pkg::PH_NAL_FIRST, avcc_pkg::PH_NAL_BODY: begin
          if (parse_phase == avcc_pkg::PH_NAL_FIRST) begin
            unit_type = b[4:0];
            drop_nal = (unit_type == avcc_pkg::NAL_AUD) ||
                       (drop_ps && (unit_type == avcc_pkg::NAL_SPS ||
                                    unit_type == avcc_pkg::NAL_PPS));
            if (!drop_nal) push_start_code();
            parse_phase = avcc_pkg::PH_NAL_BODY;
          end
          if (!drop_nal) push_byte(b);
          smp_left = smp_left - 1'b1;
          nal_left = nal_left - 1;
          if (nal_left == 0) next_nal();
        end
        avcc_pkg::PH_DRAIN: begin
          smp_left = smp_left - 1'b1;
          if (smp_left == 0) parse_phase = avcc_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  endtask

  // Watch the channels at each edge
  always @(posedge clk) begin
    annexb_item_t want;
    if (!rst_n) begin
      annexb_q.delete();
      parse_phase = avcc_pkg::PH_IDLE;
      smp_left = '0;
      pfx_acc = '0;
      pfx_seen = '0;
      nal_left = '0;
      drop_nal = 1'b0;
      drop_ps = 1'b0;
      pfx_reg = avcc_pkg::PFX_RESET;
    end else begin
      if (cfg_valid && cfg_ready) pfx_reg = cfg_data;
      if (in_tvalid && in_tready)
        predict_annexb(in_tuser, in_tdata[7:0], in_tdata[8 +: SLB], in_tdata[8 + SLB]);
      if (out_tvalid && out_tready) begin
        checked++;
        if (annexb_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected item: expected none, got byte %h valid %b last %b status %0d",
                   $time, out_tdata[7:0], out_tuser, out_tlast, out_tdata[9:8]);
        end else begin
          want = annexb_q.pop_back();
          if (out_tdata[7:0] != want.data || out_tuser != want.is_byte ||
              out_tlast != want.eos || out_tdata[9:8] != want.stat ||
              out_tdata[15:10] != '0) begin
            fails++;
            $display("%0t: item mismatch: expected byte %h valid %b last %b status %0d pad 00",
                     $time, want.data, want.is_byte, want.eos, want.stat);
            $display("%0t:                  actual byte %h valid %b last %b status %0d pad %h",
                     $time, out_tdata[7:0], out_tuser, out_tlast, out_tdata[9:8],
                     out_tdata[15:10]);
          end
        end
      end
    end
    fail_count <= fails;
    outstanding <= annexb_q.size();
    results_checked <= checked;
  end

endmodule

// ----- test/tb.sv -----
// Testbench top: drives samples and prefix sizes into the converter and reports the verdict.
`timescale 1ns / 100ps

module tb;

  localparam int SLB         = 24;
  localparam int IN_W        = ((SLB + 9 + 7) / 8) * 8;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_BYTES   = 64;
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [2:0]      cfg_data = avcc_pkg::PFX_RESET;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic            in_tuser = avcc_pkg::KIND_BYTE;   // kind
  logic [IN_W-1:0] in_tdata = '0;          // data_byte, sample_length, drop_param_sets
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [15:0]     out_tdata;              // out_byte, status
  logic            out_tuser;              // byte_valid
  logic            out_tlast;              // end_of_sample

  int fail_count, outstanding, results_checked;
  int items_sent = 0, rand_items = 0, samples = 0;
  int stall_cycles = 0;
  int hold_req = 0, hold_ack = 0, hold_left = 0;
  bit rx_steady = 1'b0;
  bit tx_idle = 1'b1;
  logic [2:0] cur_pfx = avcc_pkg::PFX_RESET;
  logic [2:0] pfx_plan [8] = '{3'd2, 3'd3, 3'd4, 3'd1, 3'd7, 3'd0, 3'd5, 3'd4};

  avcc_to_annexb_converter_core #(.SAMPLE_LENGTH_BITS(SLB)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  annexb_stream_check #(.SLB(SLB), .IN_W(IN_W)) out_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .outstanding(outstanding), .results_checked(results_checked)
  );

  always #1 clk = ~clk;

  // Receiver: random stalls, a steady stretch, and a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 29);
    end
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  // One input item, with an optional gap before it
  task automatic send_item(input logic kind, input logic [7:0] b,
                           input logic [SLB-1:0] len, input logic drop, input bit counted);
    if (tx_idle && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= IN_W'({drop, len, b});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (counted) rand_items++;
    if (kind == avcc_pkg::KIND_START) samples++;
  endtask

  // Stop offering and let every expected result drain out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_prefix(input logic [2:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_pfx = (v < avcc_pkg::PFX_MIN) ? avcc_pkg::PFX_MIN :
              (v > avcc_pkg::PFX_MAX) ? avcc_pkg::PFX_MAX : v;
  endtask

  function automatic logic [7:0] first_nal_byte();
    logic [4:0] t;
    case ($urandom_range(6))
      0:       t = avcc_pkg::NAL_SPS;
      1:       t = avcc_pkg::NAL_PPS;
      2:       t = avcc_pkg::NAL_AUD;
      3:       t = NAL_IDR;
      4:       t = NAL_SLICE;
      default: t = 5'($urandom);
    endcase
    return {3'($urandom), t};
  endfunction

  // One sample: mostly well formed, some truncated, overrunning, cut short or noise
  task automatic send_sample(input int pfx);
    logic [7:0] bytes_a [MAX_BYTES];
    logic [SLB-1:0] len;
    logic drop;
    int flavor, n_nal, nal_len, decl, cut, nb;
    nb = 0;
    flavor = $urandom_range(99);
    drop = 1'($urandom_range(1));
    if (flavor >= 22 && flavor < 28) begin
      // random length, a few bytes, then abandoned by the next start
      send_item(avcc_pkg::KIND_START, 8'($urandom), SLB'($urandom), drop, 1'b1);
      repeat ($urandom_range(3, 6))
        send_item(avcc_pkg::KIND_BYTE, 8'($urandom), SLB'($urandom), 1'($urandom), 1'b1);
      return;
    end
    n_nal = $urandom_range(1, 3);
    for (int i = 0; i < n_nal; i++) begin
      nal_len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 5);
      decl = nal_len;
      if (flavor >= 8 && flavor < 16 && i == n_nal - 1) decl = nal_len + $urandom_range(1, 3);
      for (int j = pfx - 1; j >= 0; j--) begin
        bytes_a[nb] = 8'(decl >> (8 * j));
        nb++;
      end
      for (int j = 0; j < nal_len; j++) begin
        bytes_a[nb] = (j == 0) ? first_nal_byte() : 8'($urandom);
        nb++;
      end
    end
    if (flavor < 8 && pfx > 1) begin
      repeat ($urandom_range(1, pfx - 1)) begin
        bytes_a[nb] = 8'($urandom);
        nb++;
      end
    end
    len = SLB'(nb);
    if (flavor >= 16 && flavor < 22) begin
      cut = $urandom_range(1, nb);
      nb = cut;
    end
    send_item(avcc_pkg::KIND_START, 8'($urandom), len, drop, 1'b1);
    for (int k = 0; k < nb; k++)
      send_item(avcc_pkg::KIND_BYTE, bytes_a[k], SLB'($urandom), 1'($urandom), 1'b1);
    // stray byte with no open sample
    if (flavor >= 28 && $urandom_range(9) == 0)
      send_item(avcc_pkg::KIND_BYTE, 8'($urandom), SLB'($urandom), 1'($urandom), 1'b0);
  endtask

  initial begin
    int start_n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte with no sample open, empty sample
    send_item(avcc_pkg::KIND_BYTE, 8'h5A, '1, 1'b1, 1'b0);
    send_item(avcc_pkg::KIND_START, 8'hFF, '0, 1'b0, 1'b0);
    // Longest sample, prefix size shrinks to 2 after two prefix bytes
    send_item(avcc_pkg::KIND_START, 8'h00, '1, 1'b1, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h00, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h00, '0, 1'b0, 1'b0);
    wait_idle();
    write_prefix(3'd2);
    send_item(avcc_pkg::KIND_BYTE, 8'h03, '0, 1'b0, 1'b0);
    // SPS dropped under the drop flag, then a zero-length NAL
    send_item(avcc_pkg::KIND_BYTE, 8'h67, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h11, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h22, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h00, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h00, '0, 1'b0, 1'b0);
    // New start abandons the open sample; one byte cannot hold a 2-byte prefix
    send_item(avcc_pkg::KIND_START, 8'h00, SLB'(1), 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'hFF, '0, 1'b0, 1'b0);
    wait_idle();
    write_prefix(3'd1);
    // Delimiter NAL dropped, IDR NAL passed
    send_item(avcc_pkg::KIND_START, 8'h00, SLB'(5), 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h02, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h09, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h00, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h01, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h65, '0, 1'b0, 1'b0);
    // NAL overruns with bytes left to drain, then at the very end of a sample
    send_item(avcc_pkg::KIND_START, 8'h00, SLB'(3), 1'b1, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h05, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h00, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h00, '0, 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_START, 8'h00, SLB'(1), 1'b0, 1'b0);
    send_item(avcc_pkg::KIND_BYTE, 8'h01, '0, 1'b0, 1'b0);

    // Random phases, one prefix size each
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_prefix(pfx_plan[p]);
      rx_steady <= (p == 2);
      tx_idle = (p != 2);
      if (p == 1) hold_req <= hold_req + 1;
      start_n = rand_items;
      while (rand_items - start_n < 16) send_sample(cur_pfx);
    end
    wait_idle();

    $display("%0d input items in %0d samples, prefix register 0 to 7, one long output hold-off",
             items_sent, samples);
    $display("%0d result items compared, %0d mismatches, %0d left over",
             results_checked, fail_count, outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
